@@ rtl/rhr_pkg.sv @@
// shared types, constants and the sine table of the radial hand rasterizer
package rhr_pkg;

  localparam int unsigned MaxPointsDefault = 64;

  localparam int unsigned PosW    = 6;
  localparam int unsigned LenW    = 7;
  localparam int unsigned GlyphW  = 8;
  localparam int unsigned RowW    = 11;
  localparam int unsigned ColW    = 12;
  localparam int unsigned CtrRowW = 9;
  localparam int unsigned CtrColW = 10;
  localparam int unsigned AspectW = 3;
  localparam int unsigned SinW    = 17;
  localparam int unsigned FracW   = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [PosW-1:0] Quarter  = PosW'(15);
  localparam logic [PosW-1:0] FullTurn = PosW'(60);

  localparam logic [CfgIdxW-1:0] CfgCenterCol = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCenterRow = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgAspect    = CfgIdxW'(2);

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [LenW-1:0]   hand_length;
    logic [GlyphW-1:0] glyph;
  } rhr_in_t;

  typedef struct packed {
    logic signed [RowW-1:0] row;
    logic signed [ColW-1:0] col;
    logic [GlyphW-1:0]      glyph_out;
    logic                   last;
  } rhr_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rhr_acc_ctrl_t;

  // sin(k * 6 deg) in Q2.14, rounded to nearest
  function automatic logic signed [SinW-1:0] sin_q14(input logic [PosW-1:0] k);
    logic signed [SinW-1:0] v;
    unique case (k)
      6'd0:  v = 17'sd0;
      6'd1:  v = 17'sd1713;
      6'd2:  v = 17'sd3406;
      6'd3:  v = 17'sd5063;
      6'd4:  v = 17'sd6664;
      6'd5:  v = 17'sd8192;
      6'd6:  v = 17'sd9630;
      6'd7:  v = 17'sd10963;
      6'd8:  v = 17'sd12176;
      6'd9:  v = 17'sd13255;
      6'd10: v = 17'sd14189;
      6'd11: v = 17'sd14968;
      6'd12: v = 17'sd15582;
      6'd13: v = 17'sd16026;
      6'd14: v = 17'sd16294;
      6'd15: v = 17'sd16384;
      6'd16: v = 17'sd16294;
      6'd17: v = 17'sd16026;
      6'd18: v = 17'sd15582;
      6'd19: v = 17'sd14968;
      6'd20: v = 17'sd14189;
      6'd21: v = 17'sd13255;
      6'd22: v = 17'sd12176;
      6'd23: v = 17'sd10963;
      6'd24: v = 17'sd9630;
      6'd25: v = 17'sd8192;
      6'd26: v = 17'sd6664;
      6'd27: v = 17'sd5063;
      6'd28: v = 17'sd3406;
      6'd29: v = 17'sd1713;
      6'd30: v = 17'sd0;
      6'd31: v = -17'sd1713;
      6'd32: v = -17'sd3406;
      6'd33: v = -17'sd5063;
      6'd34: v = -17'sd6664;
      6'd35: v = -17'sd8192;
      6'd36: v = -17'sd9630;
      6'd37: v = -17'sd10963;
      6'd38: v = -17'sd12176;
      6'd39: v = -17'sd13255;
      6'd40: v = -17'sd14189;
      6'd41: v = -17'sd14968;
      6'd42: v = -17'sd15582;
      6'd43: v = -17'sd16026;
      6'd44: v = -17'sd16294;
      6'd45: v = -17'sd16384;
      6'd46: v = -17'sd16294;
      6'd47: v = -17'sd16026;
      6'd48: v = -17'sd15582;
      6'd49: v = -17'sd14968;
      6'd50: v = -17'sd14189;
      6'd51: v = -17'sd13255;
      6'd52: v = -17'sd12176;
      6'd53: v = -17'sd10963;
      6'd54: v = -17'sd9630;
      6'd55: v = -17'sd8192;
      6'd56: v = -17'sd6664;
      6'd57: v = -17'sd5063;
      6'd58: v = -17'sd3406;
      6'd59: v = -17'sd1713;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rhr_accum_unit.sv @@
// shared step unit: per-hand slopes, offset accumulators and truncating shift
module rhr_accum_unit #(
  parameter int unsigned MAX_POINTS = rhr_pkg::MaxPointsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rhr_pkg::rhr_acc_ctrl_t            ctrl_i,
  input  logic [rhr_pkg::PosW-1:0]          pos_i,
  input  logic [rhr_pkg::AspectW-1:0]       aspect_i,
  output logic signed [rhr_pkg::RowW-1:0]   row_off_o,
  output logic signed [rhr_pkg::ColW-1:0]   col_off_o
);
  import rhr_pkg::*;

  localparam int unsigned StepW = $clog2(MAX_POINTS + 1);
  localparam int unsigned RAccW = StepW + FracW + 1;
  localparam int unsigned CSlpW = SinW + 1;
  localparam int unsigned CAccW = StepW + FracW + 4;
  localparam int unsigned ProdW = SinW + AspectW + 1;

  logic signed [SinW-1:0]  s_q;
  logic signed [CSlpW-1:0] c_q;
  logic signed [RAccW-1:0] row_acc_q, row_acc_d;
  logic signed [CAccW-1:0] col_acc_q, col_acc_d;

  logic [PosW-1:0]         sidx;
  logic signed [SinW-1:0]  sin_s, sin_c;
  logic signed [ProdW-1:0] prod;
  logic signed [RAccW-1:0] row_sh;
  logic signed [CAccW-1:0] col_sh;
  logic                    row_rnd, col_rnd;

  // row uses the angle a quarter turn back
  always_comb begin
    sidx  = (pos_i >= Quarter) ? (pos_i - Quarter) : (pos_i + (FullTurn - Quarter));
    sin_s = sin_q14(sidx);
    sin_c = sin_q14(pos_i);
    prod  = sin_c * $signed({1'b0, aspect_i});
  end

  // value after the next step, then truncation toward zero
  always_comb begin
    row_acc_d = row_acc_q + RAccW'(s_q);
    col_acc_d = col_acc_q + CAccW'(c_q);
    row_sh    = row_acc_d >>> FracW;
    col_sh    = col_acc_d >>> FracW;
    row_rnd   = row_acc_d[RAccW-1] && (|row_acc_d[FracW-1:0]);
    col_rnd   = col_acc_d[CAccW-1] && (|col_acc_d[FracW-1:0]);
    row_off_o = RowW'(row_sh) + RowW'({1'b0, row_rnd});
    col_off_o = ColW'(col_sh) + ColW'({1'b0, col_rnd});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_acc_q <= '0;
      col_acc_q <= '0;
    end else if (ctrl_i.load) begin
      row_acc_q <= '0;
      col_acc_q <= '0;
    end else if (ctrl_i.step) begin
      row_acc_q <= row_acc_d;
      col_acc_q <= col_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      s_q <= sin_s;
      c_q <= CSlpW'(prod);
    end
  end

endmodule

@@ rtl/radial_hand_rasterizer.sv @@
// top level of the radial hand rasterizer: sequencer, config registers, output register
// a taken input beat moves the sequencer to setup, which loads the step unit, then run
// throughput: one cell per cycle from the shared step unit while the output does not
//   stall; the input stalls until a hand ends, and a hand of zero cells stays idle
// reset: asynchronous active low; sequencer idle, output empty, registers at
//   center_col 40, center_row 12, aspect 2
module radial_hand_rasterizer #(
  parameter int unsigned MAX_POINTS = rhr_pkg::MaxPointsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rhr_pkg::rhr_in_t              in_data_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rhr_pkg::rhr_out_t             out_data_o,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [rhr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rhr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import rhr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRun
  } state_e;

  state_e state_q;

  // config registers
  logic [CtrColW-1:0] center_col_q;
  logic [CtrRowW-1:0] center_row_q;
  logic [AspectW-1:0] aspect_q;

  // per-hand context
  logic [PosW-1:0]    pos_q;
  logic [GlyphW-1:0]  glyph_q;
  logic [CntW-1:0]    remain_q;

  // output register
  logic               out_valid_q;
  rhr_out_t           out_data_q;

  logic               in_beat;
  logic               slot_free;
  logic               do_step;
  logic [LenW-1:0]    cnt_raw;
  logic [CntW-1:0]    cnt_sat;
  logic [PosW-1:0]    pos_sat;
  rhr_acc_ctrl_t      acc_ctrl;
  logic signed [RowW-1:0] row_off;
  logic signed [ColW-1:0] col_off;

  assign in_stall_o  = (state_q != StIdle);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the output register takes a new cell when empty or being drained
  assign slot_free = !out_valid_q || !out_stall_i;
  assign do_step   = (state_q == StRun) && slot_free;

  assign acc_ctrl.load = (state_q == StSetup);
  assign acc_ctrl.step = do_step;

  // cell count: length minus one, floored at zero, capped at the point limit
  always_comb begin
    cnt_raw = (in_data_i.hand_length > LenW'(1)) ? (in_data_i.hand_length - LenW'(1))
                                                 : '0;
    if ({1'b0, cnt_raw} > 8'(MAX_POINTS)) begin
      cnt_sat = CntW'(MAX_POINTS);
    end else begin
      cnt_sat = CntW'(cnt_raw);
    end
    // positions past a full turn clamp to the top
    pos_sat = (in_data_i.position > FullTurn) ? FullTurn : in_data_i.position;
  end

  rhr_accum_unit #(
    .MAX_POINTS (MAX_POINTS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .pos_i     (pos_q),
    .aspect_i  (aspect_q),
    .row_off_o (row_off),
    .col_off_o (col_off)
  );

  // config writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= CtrColW'(40);
      center_row_q <= CtrRowW'(12);
      aspect_q     <= AspectW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCenterCol: center_col_q <= cfg_wdata_i[CtrColW-1:0];
        CfgCenterRow: center_row_q <= cfg_wdata_i[CtrRowW-1:0];
        CfgAspect:    aspect_q     <= cfg_wdata_i[AspectW-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drained with nothing new behind it
      if (out_valid_q && !out_stall_i && !do_step) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            remain_q <= cnt_sat;
            // a hand with no cells never leaves idle
            if (cnt_sat != '0) begin
              state_q <= StSetup;
            end
          end
        end
        StSetup: begin
          state_q <= StRun;
        end
        StRun: begin
          if (do_step) begin
            out_valid_q <= 1'b1;
            remain_q    <= remain_q - CntW'(1);
            if (remain_q == CntW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pos_q   <= pos_sat;
      glyph_q <= in_data_i.glyph;
    end
    if (do_step) begin
      out_data_q.row       <= $signed({2'b00, center_row_q}) + row_off;
      out_data_q.col       <= $signed({2'b00, center_col_q}) + col_off;
      out_data_q.glyph_out <= glyph_q;
      out_data_q.last      <= (remain_q == CntW'(1));
    end
  end

`ifndef SYNTHESIS
  a_run_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> remain_q != '0)
    else $error("run state with no cells left");

  a_setup_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSetup |=> state_q == StRun)
    else $error("setup did not advance to run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step && remain_q == CntW'(1) |=> state_q == StIdle && out_valid_q && out_data_q.last)
    else $error("final cell did not end the hand");

  a_empty_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && cnt_sat == '0 |=> state_q == StIdle)
    else $error("empty hand left idle");
`endif

endmodule
